// ===== src/epr_pkg.sv =====
// Package with payload types, constants and helper functions for the pose transform.
`default_nettype none
package epr_pkg;

  typedef struct packed {
    logic               command;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [15:0] in_pitch;
    logic signed [15:0] in_yaw;
    logic signed [15:0] in_roll;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] out_pitch;
    logic signed [15:0] out_yaw;
    logic signed [15:0] out_roll;
    logic               gimbal_lock;
  } out_word_t;

  localparam logic [2:0] REG_POSE_X     = 3'd0;
  localparam logic [2:0] REG_POSE_Y     = 3'd1;
  localparam logic [2:0] REG_POSE_Z     = 3'd2;
  localparam logic [2:0] REG_POSE_PITCH = 3'd3;
  localparam logic [2:0] REG_POSE_YAW   = 3'd4;
  localparam logic [2:0] REG_POSE_ROLL  = 3'd5;

  localparam logic COMMAND_TO_LOCAL = 1'b0;
  localparam logic COMMAND_TO_WORLD = 1'b1;

  localparam int AngleTableLen = 24;
  localparam logic signed [35:0] GAIN_INV_Q30 = 36'sd652032874;
  localparam logic [63:0] GIMBAL_SQ_Q60 = 64'd1152921504606;

  // Arctangent of 2^-i as a 32 bit binary angle.
  function automatic logic signed [33:0] angle_step(input int idx);
    logic signed [33:0] t [AngleTableLen];
    t = '{34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
          34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
          34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772, 34'sd166886,
          34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430, 34'sd5215,
          34'sd2608, 34'sd1304, 34'sd652, 34'sd326, 34'sd163, 34'sd81};
    return t[idx];
  endfunction

  // Q30 product with round half up: floor((a*b + 2^29) / 2^30).
  function automatic logic signed [35:0] mul30(input logic signed [35:0] a,
                                               input logic signed [35:0] b);
    logic signed [71:0] p;
    p = a * b + 72'sd536870912;
    return p[65:30];
  endfunction

  // Same rounding for a matrix entry times a 34 bit position.
  function automatic logic signed [40:0] mulpos(input logic signed [35:0] a,
                                                input logic signed [33:0] b);
    logic signed [69:0] p;
    p = a * b + 70'sd536870912;
    return 41'($signed(p[69:30]));
  endfunction

endpackage
`default_nettype wire

// ===== src/epr_cordic_rot.sv =====
// Pipelined rotation-mode CORDIC producing sine and cosine in Q30.
`default_nettype none
module epr_cordic_rot #(
  parameter int Steps = 16
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [15:0]        ang,
  output logic signed [35:0]      sin_o,
  output logic signed [35:0]      cos_o
);
  logic signed [35:0] x_r [Steps+1];
  logic signed [35:0] y_r [Steps+1];
  logic signed [33:0] z_r [Steps+1];
  logic               neg_r [Steps+1];
  logic [31:0]        a32;
  logic               neg;

  always_comb begin
    a32 = {ang, 16'h0000};
    neg = (a32[31:30] == 2'd1) || (a32[31:30] == 2'd2);
    if (neg) a32 = a32 + 32'h8000_0000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= epr_pkg::GAIN_INV_Q30;
      y_r[0]   <= '0;
      z_r[0]   <= {{2{a32[31]}}, a32};
      neg_r[0] <= neg;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - epr_pkg::angle_step(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + epr_pkg::angle_step(i);
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  assign cos_o = neg_r[Steps] ? -x_r[Steps] : x_r[Steps];
  assign sin_o = neg_r[Steps] ? -y_r[Steps] : y_r[Steps];
endmodule
`default_nettype wire

// ===== src/epr_cordic_vec.sv =====
// Pipelined vectoring-mode CORDIC returning a rounded 16 bit binary angle.
`default_nettype none
module epr_cordic_vec #(
  parameter int Steps = 16
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [37:0] y_i,
  input  wire logic signed [37:0] x_i,
  output logic [15:0]             ang_o
);
  logic signed [39:0] x_r [Steps+1];
  logic signed [39:0] y_r [Steps+1];
  logic signed [33:0] z_r [Steps+1];
  logic               zero_r [Steps+1];
  logic [31:0]        zw;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_i == 0) && (y_i == 0);
      if (x_i < 0) begin
        x_r[0] <= -40'(x_i);
        y_r[0] <= -40'(y_i);
        z_r[0] <= 34'sd2147483648;
      end else begin
        x_r[0] <= 40'(x_i);
        y_r[0] <= 40'(y_i);
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i][39]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - epr_pkg::angle_step(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + epr_pkg::angle_step(i);
        end
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  assign zw    = z_r[Steps][31:0] + 32'h0000_8000;
  assign ang_o = zero_r[Steps] ? 16'h0000 : zw[31:16];
endmodule
`default_nettype wire

// ===== src/euler_pose_relative_transform_top.sv =====
// Top level of the pose transform: reference registers, matrix pipeline and angle extraction.
//
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid/in_ready   | epr_pkg::in_word_t
// out     | output    | out_valid/out_ready | epr_pkg::out_word_t
// cfg     | input     | cfg_valid/cfg_ready | cfg_index + cfg_data
//
// One word enters per cycle while the output is not stalled. The depth is set by the
// sine/cosine CORDIC (step count capped at 24), five matrix stages, the 33 stage square
// root and the atan2 CORDIC.
// Reset (rst_n low, synchronous) clears the pose registers and all valid bits.
// The pipeline advances only when its last stage is empty or being taken, so a
// stall freezes every stage and no word is lost or repeated.
`default_nettype none
module euler_pose_relative_transform_top #(
  parameter int CORDIC_ITERATIONS      = 16,
  parameter int POSITION_FRACTION_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire epr_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output epr_pkg::out_word_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  // The step count saturates at the table length.
  localparam int Steps = (CORDIC_ITERATIONS > epr_pkg::AngleTableLen) ?
                         epr_pkg::AngleTableLen : CORDIC_ITERATIONS;
  // Positions are linear; the fraction width only names the format.
  localparam int FracBits = POSITION_FRACTION_BITS;
  localparam int SqrtSteps = 32;
  // Stage counts of each section.
  localparam int LatA = Steps + 1;      // sine/cosine
  localparam int LatB = 5;              // matrix build, products
  localparam int LatC = SqrtSteps + 1;  // square root
  localparam int LatD = Steps + 1;      // atan2
  localparam int Depth = LatA + LatB + LatC + LatD;

  logic signed [31:0] pose_x_r, pose_y_r, pose_z_r;
  logic [15:0]        pose_pitch_r, pose_yaw_r, pose_roll_r;
  logic               adv;
  logic [Depth-1:0]   vld_r;

  assign adv       = !vld_r[Depth-1] || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[Depth-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r <= '0; pose_y_r <= '0; pose_z_r <= '0;
      pose_pitch_r <= '0; pose_yaw_r <= '0; pose_roll_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        epr_pkg::REG_POSE_X:     pose_x_r     <= cfg_data;
        epr_pkg::REG_POSE_Y:     pose_y_r     <= cfg_data;
        epr_pkg::REG_POSE_Z:     pose_z_r     <= cfg_data;
        epr_pkg::REG_POSE_PITCH: pose_pitch_r <= cfg_data[15:0];
        epr_pkg::REG_POSE_YAW:   pose_yaw_r   <= cfg_data[15:0];
        epr_pkg::REG_POSE_ROLL:  pose_roll_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[Depth-2:0], in_valid};
  end

  // Section A: six sine/cosine pipelines; the word's other fields ride alongside.
  logic signed [35:0] s_v [6];
  logic signed [35:0] c_v [6];
  logic [15:0]        ang_in [6];
  assign ang_in[0] = pose_pitch_r; assign ang_in[1] = pose_yaw_r;
  assign ang_in[2] = pose_roll_r;
  assign ang_in[3] = in_data.in_pitch; assign ang_in[4] = in_data.in_yaw;
  assign ang_in[5] = in_data.in_roll;
  for (genvar k = 0; k < 6; k++) begin : g_sc
    epr_cordic_rot #(.Steps(Steps)) u_rot (
      .clk(clk), .en(adv), .ang(ang_in[k]), .sin_o(s_v[k]), .cos_o(c_v[k]));
  end

  logic signed [33:0] pos_a_r [LatA][3];
  logic signed [31:0] org_a_r [LatA][3];
  logic               cmd_a_r [LatA];
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_a_r[0]    <= in_data.command;
      org_a_r[0][0] <= pose_x_r; org_a_r[0][1] <= pose_y_r; org_a_r[0][2] <= pose_z_r;
      if (in_data.command == epr_pkg::COMMAND_TO_WORLD) begin
        pos_a_r[0][0] <= 34'(in_data.in_x);
        pos_a_r[0][1] <= 34'(in_data.in_y);
        pos_a_r[0][2] <= 34'(in_data.in_z);
      end else begin
        pos_a_r[0][0] <= 34'(in_data.in_x) - 34'(pose_x_r);
        pos_a_r[0][1] <= 34'(in_data.in_y) - 34'(pose_y_r);
        pos_a_r[0][2] <= 34'(in_data.in_z) - 34'(pose_z_r);
      end
      for (int i = 1; i < LatA; i++) begin
        cmd_a_r[i] <= cmd_a_r[i-1];
        pos_a_r[i] <= pos_a_r[i-1];
        org_a_r[i] <= org_a_r[i-1];
      end
    end
  end

  // Section B, stage 1: first-level products for both matrices.
  typedef logic signed [35:0] q_t;
  q_t b1_r [2][8];
  q_t sp_r [2];
  logic signed [33:0] pos_b1_r [3];
  logic signed [31:0] org_b1_r [3];
  logic cmd_b1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 2; m++) begin
        // p=3m, y=3m+1, r=3m+2
        b1_r[m][0] <= epr_pkg::mul30(c_v[3*m], c_v[3*m+1]);   // cp*cy
        b1_r[m][1] <= epr_pkg::mul30(c_v[3*m], s_v[3*m+1]);   // cp*sy
        b1_r[m][2] <= epr_pkg::mul30(c_v[3*m+2], c_v[3*m+1]); // cr*cy
        b1_r[m][3] <= epr_pkg::mul30(c_v[3*m+2], s_v[3*m+1]); // cr*sy
        b1_r[m][4] <= epr_pkg::mul30(s_v[3*m+2], c_v[3*m+1]); // sr*cy
        b1_r[m][5] <= epr_pkg::mul30(s_v[3*m+2], s_v[3*m+1]); // sr*sy
        b1_r[m][6] <= epr_pkg::mul30(s_v[3*m+2], c_v[3*m]);   // sr*cp
        b1_r[m][7] <= epr_pkg::mul30(c_v[3*m+2], c_v[3*m]);   // cr*cp
        sp_r[m] <= s_v[3*m];
      end
      pos_b1_r <= pos_a_r[LatA-1];
      org_b1_r <= org_a_r[LatA-1];
      cmd_b1_r <= cmd_a_r[LatA-1];
    end
  end

  // Stage 2: finished rotation matrices.
  q_t mt_r [2][3][3];
  logic signed [33:0] pos_b2_r [3];
  logic signed [31:0] org_b2_r [3];
  logic cmd_b2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 2; m++) begin
        mt_r[m][0][0] <= b1_r[m][0];
        mt_r[m][1][0] <= b1_r[m][1];
        mt_r[m][2][0] <= -sp_r[m];
        mt_r[m][0][1] <= epr_pkg::mul30(sp_r[m], b1_r[m][4]) - b1_r[m][3];
        mt_r[m][1][1] <= epr_pkg::mul30(sp_r[m], b1_r[m][5]) + b1_r[m][2];
        mt_r[m][2][1] <= b1_r[m][6];
        mt_r[m][0][2] <= epr_pkg::mul30(sp_r[m], b1_r[m][2]) + b1_r[m][5];
        mt_r[m][1][2] <= epr_pkg::mul30(sp_r[m], b1_r[m][3]) - b1_r[m][4];
        mt_r[m][2][2] <= b1_r[m][7];
      end
      pos_b2_r <= pos_b1_r; org_b2_r <= org_b1_r; cmd_b2_r <= cmd_b1_r;
    end
  end

  // Stage 3: all products of the composed matrix and the rotated position.
  q_t rsel [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        rsel[i][j] = (cmd_b2_r == epr_pkg::COMMAND_TO_WORLD) ? mt_r[0][i][j] : mt_r[0][j][i];
  end
  q_t cp_r [3][3][3];
  logic signed [40:0] pp_r [3][3];
  logic signed [31:0] org_b3_r [3];
  logic cmd_b3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_r[i][j] <= epr_pkg::mulpos(rsel[i][j], pos_b2_r[j]);
          for (int k = 0; k < 3; k++)
            cp_r[i][j][k] <= epr_pkg::mul30(rsel[i][k], mt_r[1][k][j]);
        end
      end
      org_b3_r <= org_b2_r; cmd_b3_r <= cmd_b2_r;
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) return 32'sh7fffffff;
    if (v < -44'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Stage 4: sums; positions finish with saturation and, for to-world words, the origin.
  q_t cm_r [3][3];
  logic signed [31:0] pos_b4_r [3];
  logic signed [43:0] acc;
  always_comb acc = '0;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++)
          cm_r[i][j] <= cp_r[i][j][0] + cp_r[i][j][1] + cp_r[i][j][2];
        pos_b4_r[i] <= sat32(44'(pp_r[i][0]) + 44'(pp_r[i][1]) + 44'(pp_r[i][2])
                             + ((cmd_b3_r == epr_pkg::COMMAND_TO_WORLD) ?
                                44'(org_b3_r[i]) : acc));
      end
    end
  end

  // Stage 5: horizontal length squared.
  logic [63:0] sq_r;
  q_t f2_r, m21_r, m22_r, m01_r, m11_r, f0_r, f1_r;
  logic signed [31:0] pos_b5_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r <= 64'(cm_r[0][0]) * 64'(cm_r[0][0]) + 64'(cm_r[1][0]) * 64'(cm_r[1][0]);
      f0_r <= cm_r[0][0]; f1_r <= cm_r[1][0]; f2_r <= cm_r[2][0];
      m21_r <= cm_r[2][1]; m22_r <= cm_r[2][2];
      m01_r <= cm_r[0][1]; m11_r <= cm_r[1][1];
      pos_b5_r <= pos_b4_r;
    end
  end

  // Section C: one bit of the integer square root per stage.
  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
    logic        lock;
    logic signed [37:0] y0, x1, y1, x2, y2, f2n;
    logic signed [31:0] px, py, pz;
  } sq_stage_t;
  sq_stage_t sq_st_r [LatC];
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_st_r[0].v    <= sq_r;
      sq_st_r[0].r    <= '0;
      sq_st_r[0].lock <= !(sq_r > epr_pkg::GIMBAL_SQ_Q60);
      sq_st_r[0].f2n  <= -38'(f2_r);
      if (sq_r > epr_pkg::GIMBAL_SQ_Q60) begin
        sq_st_r[0].y1 <= 38'(f1_r);  sq_st_r[0].x1 <= 38'(f0_r);
        sq_st_r[0].y2 <= 38'(m21_r); sq_st_r[0].x2 <= 38'(m22_r);
      end else begin
        sq_st_r[0].y1 <= -38'(m01_r); sq_st_r[0].x1 <= 38'(m11_r);
        sq_st_r[0].y2 <= '0;          sq_st_r[0].x2 <= '0;
      end
      sq_st_r[0].y0 <= '0;
      sq_st_r[0].px <= pos_b5_r[0]; sq_st_r[0].py <= pos_b5_r[1];
      sq_st_r[0].pz <= pos_b5_r[2];
    end
  end
  for (genvar s = 0; s < SqrtSteps; s++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * s);
    sq_stage_t st_nxt;
    always_comb begin
      st_nxt = sq_st_r[s];
      if (sq_st_r[s].v >= sq_st_r[s].r + Bit) begin
        st_nxt.v = sq_st_r[s].v - (sq_st_r[s].r + Bit);
        st_nxt.r = (sq_st_r[s].r >> 1) + Bit;
      end else begin
        st_nxt.r = sq_st_r[s].r >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) sq_st_r[s+1] <= st_nxt;
    end
  end

  // Section D: three atan2 pipelines.
  sq_stage_t sq_end;
  logic [15:0] a_p, a_y, a_r;
  assign sq_end = sq_st_r[LatC-1];
  epr_cordic_vec #(.Steps(Steps)) u_pitch (.clk(clk), .en(adv), .y_i(sq_end.f2n),
    .x_i(38'(sq_end.r)), .ang_o(a_p));
  epr_cordic_vec #(.Steps(Steps)) u_yaw (.clk(clk), .en(adv), .y_i(sq_end.y1),
    .x_i(sq_end.x1), .ang_o(a_y));
  epr_cordic_vec #(.Steps(Steps)) u_roll (.clk(clk), .en(adv), .y_i(sq_end.y2),
    .x_i(sq_end.x2), .ang_o(a_r));

  logic signed [31:0] px_d_r [LatD], py_d_r [LatD], pz_d_r [LatD];
  logic lock_d_r [LatD];
  always_ff @(posedge clk) begin
    if (adv) begin
      px_d_r[0] <= sq_end.px; py_d_r[0] <= sq_end.py; pz_d_r[0] <= sq_end.pz;
      lock_d_r[0] <= sq_end.lock;
      for (int i = 1; i < LatD; i++) begin
        px_d_r[i] <= px_d_r[i-1]; py_d_r[i] <= py_d_r[i-1];
        pz_d_r[i] <= pz_d_r[i-1]; lock_d_r[i] <= lock_d_r[i-1];
      end
    end
  end

  always_comb begin
    out_data.out_x       = px_d_r[LatD-1];
    out_data.out_y       = py_d_r[LatD-1];
    out_data.out_z       = pz_d_r[LatD-1];
    out_data.out_pitch   = a_p;
    out_data.out_yaw     = a_y;
    out_data.out_roll    = lock_d_r[LatD-1] ? 16'h0000 : a_r;
    out_data.gimbal_lock = lock_d_r[LatD-1] | (FracBits < 0);
  end

  // A stalled output word must not be replaced.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");
  // Gimbal lock always comes with zero roll.
  a_roll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.gimbal_lock |-> out_data.out_roll == 16'h0000)
    else $error("roll not zero under gimbal lock");
  // Input is taken whenever the last stage moves.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("pipeline stalled without back pressure");
endmodule
`default_nettype wire
